### sv/two_group_round_robin_task_scheduler_macros.svh
// assertion macros for the two-group round robin task scheduler
// no dependencies; included by the top level only
`ifndef TWO_GROUP_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define TWO_GROUP_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TRRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define TRRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/trrs_pkg.sv
// shared types and constants of the two-group round robin task scheduler
// no dependencies
package trrs_pkg;

  localparam int unsigned TASK_W     = 13;
  localparam int unsigned SLOT_SEL_W = 3;

  typedef enum logic [0:0] {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_t;

  // slot write request from the command decode to the slot store
  typedef struct packed {
    logic                  en;
    logic                  grp;
    logic [SLOT_SEL_W-1:0] slot;
    logic [TASK_W-1:0]     value;
  } slot_wr_t;

endpackage

### sv/two_group_round_robin_task_scheduler.sv
// two-group round robin task scheduler, top level
// depends on trrs_pkg, trrs_slot_store and the assertion macro header
//
// Two groups of SLOTS_PER_GROUP task slots, each holding a 13-bit descriptor
// index (0 = empty). A transaction is accepted when start is high and busy is
// low. A write transaction (in_cmd = 1) fills or clears one slot in the
// accepting cycle, gives no result and leaves busy low. A tick transaction
// (in_cmd = 0) first moves to the other group if it holds any task, then scans
// the current group round robin starting after its last served slot, checking
// that slot itself last. The first tick served in a group after reset serves
// slot 0 as it stands. The result appears on the out_ ports for exactly one
// cycle with out_valid high; the receiver cannot stall it, so it must take it
// then. A tick on a fresh group goes straight to the read state; otherwise the
// scan walks one slot per cycle through a single shared position incrementer
// and occupancy check, examining 1 to SLOTS_PER_GROUP slots, and when a task
// is found it goes on to read that slot; when nothing is runnable it goes
// straight to the result without a read. busy drops the cycle after
// out_valid. The descriptor memory is read at most once per tick at the chosen
// slot, with a registered read.
module two_group_round_robin_task_scheduler
  import trrs_pkg::*;
#(
  parameter int unsigned SLOTS_PER_GROUP = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic                  in_group_sel,
  input  logic [SLOT_SEL_W-1:0] in_slot_sel,
  input  logic [TASK_W-1:0]     in_slot_value,
  output logic                  out_valid,
  output logic [TASK_W-1:0]     out_task_index,
  output logic                  out_served_group,
  output logic [SLOT_SEL_W-1:0] out_served_slot,
  output logic                  out_idle
);

`include "two_group_round_robin_task_scheduler_macros.svh"

  localparam int unsigned SIDX_W = $clog2(SLOTS_PER_GROUP);
  localparam int unsigned AW     = SIDX_W + 1;
  localparam int unsigned DEPTH  = 2 << SIDX_W;
  localparam int unsigned CNT_W  = $clog2(SLOTS_PER_GROUP + 1);
  localparam logic [SIDX_W-1:0] LAST_IDX  = SIDX_W'(SLOTS_PER_GROUP - 1);
  localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(SLOTS_PER_GROUP - 1);

  // sequencer and context
  state_t            state_r, state_nxt;
  logic              cur_r, cur_nxt;
  logic [1:0]        fresh_r, fresh_nxt;
  logic [SIDX_W-1:0] last_r [2];
  logic [SIDX_W-1:0] last_nxt [2];
  logic              found_r, found_nxt;
  logic [SIDX_W-1:0] slot_r, slot_nxt;
  logic [SIDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]  step_r, step_nxt;

  // shared scan unit and handshake decode
  logic              accept;
  logic              tick_acc;
  logic              other_occ;
  logic              tick_grp;
  logic [SIDX_W-1:0] pos_inc;
  logic              hit;

  // slot store interface
  slot_wr_t          wr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [TASK_W-1:0] rd_data;
  logic [DEPTH-1:0]  occ;

  assign accept   = start && !busy;
  assign tick_acc = accept && (in_cmd == CMD_TICK);

  assign wr.en    = accept && (in_cmd == CMD_WRITE);
  assign wr.grp   = in_group_sel;
  assign wr.slot  = in_slot_sel;
  assign wr.value = in_slot_value;

  trrs_slot_store #(
    .SLOTS_PER_GROUP(SLOTS_PER_GROUP)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .occ    (occ)
  );

  // does the other group hold any task: decides the group switch on a tick
  always_comb begin
    other_occ = 1'b0;
    for (int i = 0; i < SLOTS_PER_GROUP; i++) begin
      other_occ = other_occ | occ[{~cur_r, SIDX_W'(i)}];
    end
  end

  assign tick_grp = other_occ ? ~cur_r : cur_r;

  // round robin step: next slot with wrap, and its occupancy
  assign pos_inc = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
  assign hit     = occ[{cur_r, pos_inc}];

  assign rd_addr = {cur_r, slot_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (tick_acc) begin
          state_nxt = fresh_r[tick_grp] ? ST_READ : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_READ;
        end else if (step_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy      = (state_r != ST_IDLE);
    rd_en     = (state_r == ST_READ);
    out_valid = (state_r == ST_DONE);
  end

  // datapath next values
  always_comb begin
    cur_nxt   = cur_r;
    fresh_nxt = fresh_r;
    last_nxt  = last_r;
    found_nxt = found_r;
    slot_nxt  = slot_r;
    pos_nxt   = pos_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (tick_acc) begin
          cur_nxt = tick_grp;
          if (fresh_r[tick_grp]) begin
            // first tick in this group: serve slot 0 as it stands
            fresh_nxt[tick_grp] = 1'b0;
            last_nxt[tick_grp]  = '0;
            slot_nxt            = '0;
            found_nxt           = occ[{tick_grp, SIDX_W'(0)}];
          end else begin
            pos_nxt   = last_r[tick_grp];
            step_nxt  = '0;
            found_nxt = 1'b0;
            slot_nxt  = '0;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          found_nxt       = 1'b1;
          slot_nxt        = pos_inc;
          last_nxt[cur_r] = pos_inc;
        end else begin
          pos_nxt  = pos_inc;
          step_nxt = step_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cur_r     <= 1'b0;
      fresh_r   <= 2'b11;
      last_r[0] <= '0;
      last_r[1] <= '0;
      found_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      fresh_r <= fresh_nxt;
      last_r  <= last_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    pos_r  <= pos_nxt;
    step_r <= step_nxt;
  end

  // result transaction: empty pick gives index 0 and slot 0
  assign out_task_index   = found_r ? rd_data : '0;
  assign out_served_group = cur_r;
  assign out_served_slot  = SLOT_SEL_W'(slot_r);
  assign out_idle         = ~found_r;

  `TRRS_ASSERT_NOW(a_idle_zero, clk, rst_n, out_valid && out_idle, out_task_index == '0, "idle result with nonzero index")
  `TRRS_ASSERT_NOW(a_served_occupied, clk, rst_n, out_valid && !out_idle, occ[rd_addr], "served slot is empty")
  `TRRS_ASSERT_NEXT(a_tick_busy, clk, rst_n, tick_acc, busy, "tick accepted but not busy")
  `TRRS_ASSERT_NOW(a_scan_bound, clk, rst_n, state_r == ST_SCAN, 32'(step_r) < SLOTS_PER_GROUP, "scan ran past group size")

endmodule

### sv/trrs_slot_store.sv
// slot store: descriptor memory with registered read and per-entry occupancy flags
// depends on trrs_pkg
module trrs_slot_store
  import trrs_pkg::*;
#(
  parameter int unsigned SLOTS_PER_GROUP = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  slot_wr_t                                wr,
  input  logic                                    rd_en,
  input  logic [$clog2(SLOTS_PER_GROUP):0]        rd_addr,
  output logic [TASK_W-1:0]                       rd_data,
  output logic [(2 << $clog2(SLOTS_PER_GROUP))-1:0] occ
);

  localparam int unsigned SIDX_W = $clog2(SLOTS_PER_GROUP);
  localparam int unsigned AW     = SIDX_W + 1;
  localparam int unsigned DEPTH  = 2 << SIDX_W;

  logic [TASK_W-1:0] mem [DEPTH];
  logic [TASK_W-1:0] rd_data_r;
  logic [DEPTH-1:0]  occ_r;
  logic [AW-1:0]     wr_addr;
  logic              wr_ok;

  // writes beyond the group size are dropped
  assign wr_ok   = wr.en && (32'(wr.slot) < SLOTS_PER_GROUP);
  assign wr_addr = {wr.grp, SIDX_W'(wr.slot)};

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (wr_ok) begin
      occ_r[wr_addr] <= (wr.value != '0);
    end
  end

  assign rd_data = rd_data_r;
  assign occ     = occ_r;

endmodule

### verif/tb_top.sv
// self-checking testbench for the two-group round robin task scheduler
// depends on trrs_pkg and the two_group_round_robin_task_scheduler top level
// an internal scheduler model predicts every pick; results are checked in order
module tb_top
  import trrs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOTS         = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // a tick scans at most NSLOTS slots, plus read and output cycles
  localparam int unsigned TAIL_CYCLES    = NSLOTS + 4;

  // one scheduler pick as seen on the out_ ports
  typedef struct {
    logic [TASK_W-1:0]     task_index;
    logic                  grp;
    logic [SLOT_SEL_W-1:0] slot;
    logic                  idle;
  } sched_pick_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic                  in_cmd        = CMD_TICK;
  logic                  in_group_sel  = 1'b0;
  logic [SLOT_SEL_W-1:0] in_slot_sel   = '0;
  logic [TASK_W-1:0]     in_slot_value = '0;
  logic                  busy;
  logic                  out_valid;
  logic [TASK_W-1:0]     out_task_index;
  logic                  out_served_group;
  logic [SLOT_SEL_W-1:0] out_served_slot;
  logic                  out_idle;

  // scheduler model state
  logic [TASK_W-1:0]     model_slots [2][NSLOTS];
  logic                  model_group;
  logic [SLOT_SEL_W-1:0] model_last  [2];
  logic                  model_fresh [2];

  sched_pick_t pending_picks[$];
  int          mismatches   = 0;
  int          picks_seen   = 0;
  int          stall_cycles = 0;
  bit          gaps_on      = 1'b1;

  always #4 clk = ~clk;

  two_group_round_robin_task_scheduler #(
    .SLOTS_PER_GROUP(NSLOTS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_group_sel    (in_group_sel),
    .in_slot_sel     (in_slot_sel),
    .in_slot_value   (in_slot_value),
    .out_valid       (out_valid),
    .out_task_index  (out_task_index),
    .out_served_group(out_served_group),
    .out_served_slot (out_served_slot),
    .out_idle        (out_idle)
  );

  // ---------------------------------------------------------------------------
  // model of one tick: group switch, then fresh-pointer or round robin scan
  // ---------------------------------------------------------------------------
  function automatic sched_pick_t pick_next_task();
    sched_pick_t pick;
    logic        other_occupied;
    logic        found;
    int unsigned pos;
    int unsigned g;
    other_occupied = 1'b0;
    found          = 1'b0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (model_slots[model_group ^ 1'b1][i] != '0) other_occupied = 1'b1;
    end
    // move over to the other group whenever it holds any task
    if (other_occupied) model_group = ~model_group;
    g               = 32'(model_group);
    pick.grp        = model_group;
    pick.task_index = '0;
    pick.slot       = '0;
    pick.idle       = 1'b1;
    if (model_fresh[g]) begin
      // first tick in this group since reset: slot 0 served as it stands
      model_fresh[g]  = 1'b0;
      model_last[g]   = '0;
      pick.task_index = model_slots[g][0];
      pick.idle       = (model_slots[g][0] == '0);
    end else begin
      // start after the last served slot, check that slot itself last
      pos = 32'(model_last[g]);
      for (int step = 0; step < NSLOTS; step++) begin
        pos = (pos + 1) % NSLOTS;
        if (!found && model_slots[g][pos] != '0) begin
          found           = 1'b1;
          pick.task_index = model_slots[g][pos];
          pick.slot       = pos[SLOT_SEL_W-1:0];
          pick.idle       = 1'b0;
          model_last[g]   = pos[SLOT_SEL_W-1:0];
        end
      end
      // nothing runnable leaves the pointer where it was
    end
    return pick;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one transaction, with random gaps; start is left high on return
  // ---------------------------------------------------------------------------
  task automatic send_txn(input cmd_t cmd, input logic grp,
                          input logic [SLOT_SEL_W-1:0] slot, input logic [TASK_W-1:0] value);
    if (gaps_on && $urandom_range(99) < 6) begin
      start <= 1'b0;
      // half the gaps first wait until the block has gone idle, half start at once
      if ($urandom_range(1) == 1) begin
        #1;
        while (busy) @(posedge clk);
      end
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_group_sel  <= grp;
    in_slot_sel   <= slot;
    in_slot_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    // transaction accepted at this edge: bring the model up to date
    if (cmd == CMD_WRITE) begin
      if (slot < NSLOTS) model_slots[grp][slot] = value;
    end else begin
      pending_picks.push_back(pick_next_task());
    end
  endtask

  task automatic write_slot(input logic grp, input logic [SLOT_SEL_W-1:0] slot,
                            input logic [TASK_W-1:0] value);
    send_txn(CMD_WRITE, grp, slot, value);
  endtask

  // the write fields are don't-care on a tick, so they carry random noise
  task automatic sched_tick();
    send_txn(CMD_TICK, 1'($urandom_range(1)), 3'($urandom_range(7)),
             13'($urandom_range(8191)));
  endtask

  function automatic logic [TASK_W-1:0] random_value(input int unsigned clear_pct);
    if ($urandom_range(99) < clear_pct) return '0;
    case ($urandom_range(7))
      0:       return '1;
      1:       return 13'd1;
      default: return 13'($urandom_range(8191, 1));
    endcase
  endfunction

  // stop sending and let every outstanding pick come back
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // checker: each strobed result against the oldest predicted pick
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch at pick %0d, %s: got %0d, expected %0d", picks_seen, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    sched_pick_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (pending_picks.size() == 0) begin
        report_mismatch("result with no tick outstanding", int'(out_task_index), 0);
      end else begin
        want = pending_picks.pop_front();
        if (out_task_index !== want.task_index)
          report_mismatch("task_index", int'(out_task_index), int'(want.task_index));
        if (out_served_group !== want.grp)
          report_mismatch("served_group", int'(out_served_group), int'(want.grp));
        if (out_served_slot !== want.slot)
          report_mismatch("served_slot", int'(out_served_slot), int'(want.slot));
        if (out_idle !== want.idle)
          report_mismatch("idle", int'(out_idle), int'(want.idle));
      end
      picks_seen++;
    end
  end

  // watchdog: cycles with neither an accepted transaction nor a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // fresh pointers, lone tasks, group switching, nothing runnable
  task automatic test_directed_cases();
    sched_tick();                    // fresh group 0, slot 0 empty: idle
    write_slot(1'b0, 3'd3, 13'h1FFF);
    sched_tick();                    // group 0 scans from slot 1, finds slot 3
    write_slot(1'b1, 3'd0, 13'h0001);
    sched_tick();                    // switch to group 1, fresh: slot 0 served
    sched_tick();                    // lone task in group 0 served again
    sched_tick();                    // lone task in group 1 served again
    write_slot(1'b0, 3'd7, 13'h1555);
    write_slot(1'b1, 3'd7, 13'h0AAA);
    sched_tick();                    // group 0 slot 7
    sched_tick();                    // group 1 slot 7
    sched_tick();                    // group 0 wraps round to slot 3
    write_slot(1'b0, 3'd3, 13'h0000);
    write_slot(1'b0, 3'd7, 13'h0000);
    sched_tick();                    // group 0 empty, group 1 wraps to slot 0
    sched_tick();                    // stays in group 1, slot 7
    write_slot(1'b1, 3'd0, 13'h0000);
    write_slot(1'b1, 3'd7, 13'h0000);
    sched_tick();                    // both groups empty: nothing runnable
    write_slot(1'b1, 3'd4, 13'h1FFF);
    sched_tick();                    // group 1 from slot 7 round to slot 4
    write_slot(1'b0, 3'd0, 13'h1FFF);
    sched_tick();                    // group 0, scan wraps to slot 0
  endtask

  // mixed writes and ticks with random gaps on the sender side
  task automatic test_random_mixed(input int unsigned txns);
    for (int unsigned n = 0; n < txns; n++) begin
      if ($urandom_range(99) < 50) sched_tick();
      else write_slot(1'($urandom_range(1)), 3'($urandom_range(7)), random_value(30));
    end
  endtask

  // a long stretch with no gaps at all
  task automatic test_back_to_back(input int unsigned txns);
    gaps_on = 1'b0;
    for (int unsigned n = 0; n < txns; n++) begin
      if ($urandom_range(99) < 55) sched_tick();
      else write_slot(1'($urandom_range(1)), 3'($urandom_range(7)), random_value(25));
    end
    gaps_on = 1'b1;
  endtask

  // mostly clears, so groups run empty or hold a single task
  task automatic test_sparse_groups(input int unsigned txns);
    for (int unsigned n = 0; n < txns; n++) begin
      if ($urandom_range(99) < 50) sched_tick();
      else write_slot(1'($urandom_range(1)), 3'($urandom_range(7)), random_value(70));
    end
  endtask

  initial begin
    for (int g = 0; g < 2; g++) begin
      for (int i = 0; i < NSLOTS; i++) model_slots[g][i] = '0;
      model_last[g]  = '0;
      model_fresh[g] = 1'b1;
    end
    model_group = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_mixed(800);
    // sender holds off until the block has drained
    wait_for_results();
    test_back_to_back(500);
    wait_for_results();
    test_sparse_groups(400);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### two_group_round_robin_task_scheduler.f
+incdir+sv
sv/trrs_pkg.sv
sv/trrs_slot_store.sv
sv/two_group_round_robin_task_scheduler.sv
verif/tb_top.sv
